FILE: sv/ffa_pkg.sv
package ffa_pkg;

  localparam int unsigned ARENA_BYTES_DEF = 65536;
  localparam int unsigned MAX_ENTRIES_DEF = 32;

  // working width for offsets and ends, covers the largest arena
  localparam int WW  = 22;
  localparam int LW  = 17;
  localparam int OW  = 16;
  localparam int KW  = 2;
  localparam int STW = 3;
  localparam int PW  = 8;

  localparam logic [STW-1:0] ST_OK      = 3'd0;
  localparam logic [STW-1:0] ST_BAD     = 3'd1;
  localparam logic [STW-1:0] ST_NOSPACE = 3'd2;
  localparam logic [STW-1:0] ST_FULL    = 3'd3;
  localparam logic [STW-1:0] ST_MISS    = 3'd4;

  typedef enum logic [KW-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CHECK = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE
  } cell_op_t;

  typedef struct packed {
    logic [LW-1:0] len;
    logic [LW-1:0] mask;
    logic [OW-1:0] off;
  } req_t;

  typedef struct packed {
    cell_op_t      op;
    logic [PW-1:0] pos;
    logic [WW-1:0] start;
    logic [LW-1:0] len;
  } cell_cmd_t;

  typedef struct packed {
    logic          fit;
    logic          match;
    logic          in_span;
    logic [WW-1:0] cand;
    logic [WW-1:0] end_ofs;
  } cell_flags_t;

endpackage

FILE: sv/ffa_cell.sv
module ffa_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned SW  = 16
) (
  input  logic                      clk,
  input  ffa_pkg::cell_cmd_t        cmd,
  input  ffa_pkg::req_t             req,
  input  logic [SW-1:0]             left_start,
  input  logic [ffa_pkg::LW-1:0]    left_len,
  input  logic [SW-1:0]             right_start,
  input  logic [ffa_pkg::LW-1:0]    right_len,
  input  logic [ffa_pkg::WW-1:0]    left_end,
  output logic [SW-1:0]             start_o,
  output logic [ffa_pkg::LW-1:0]    len_o,
  output ffa_pkg::cell_flags_t      flags
);
  import ffa_pkg::*;

  logic [SW-1:0] start_r, start_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [WW-1:0] s_w, l_w, off_w, len_w, mask_w, cand, d;
  logic [PW-1:0] my_idx;

  assign my_idx = PW'(IDX);

  always_comb begin
    start_nxt = start_r;
    len_nxt   = len_r;
    case (cmd.op)
      OP_INSERT: begin
        if (my_idx > cmd.pos) begin
          start_nxt = left_start;
          len_nxt   = left_len;
        end else if (my_idx == cmd.pos) begin
          start_nxt = cmd.start[SW-1:0];
          len_nxt   = cmd.len;
        end
      end
      OP_DELETE: begin
        if (my_idx >= cmd.pos) begin
          start_nxt = right_start;
          len_nxt   = right_len;
        end
      end
      OP_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    len_r   <= len_nxt;
  end

  // gap before this entry starts at the aligned end of the left neighbor
  always_comb begin
    s_w    = WW'(start_r);
    l_w    = WW'(len_r);
    off_w  = WW'(req.off);
    len_w  = WW'(req.len);
    mask_w = WW'(req.mask);
    cand   = (left_end + mask_w) & ~mask_w;
    d      = off_w - s_w;
    flags.fit     = (cand <= s_w) && ((s_w - cand) >= len_w);
    flags.match   = (s_w == off_w);
    flags.in_span = (off_w >= s_w) && (d <= l_w) && (len_w <= (l_w - d));
    flags.cand    = cand;
    flags.end_ofs = s_w + l_w;
  end

  assign start_o = start_r;
  assign len_o   = len_r;

endmodule

FILE: sv/first_fit_arena_allocator_unit.sv
// First-fit arena allocator.
// Input channel (in_valid/in_stall): kind, length, alignment, offset. One
// transaction is taken at a time; in_stall is high from acceptance until the
// result is registered. Output channel (out_valid/out_stall): status and
// block_start, one result per input transaction.
// The live allocations sit in a row of cells, sorted by start. Each cell
// works out its own gap fit, start match and span test from its contents and
// the end of its left neighbor. A scan pointer walks the row one cell a
// cycle; insert and delete shift the row by one place, all cells at once.
// out_valid rises once the scan reaches the hit at index k (the entry count
// on a miss or an append); bad requests answer from the first scan step.
// The next transaction is taken only after the result registers and the
// state returns to idle, so the rate is set by the scan.
// Reset empties the table (count to zero); stored entries are not cleared.
// While a result waits under out_stall, a new transaction may be accepted and
// scanned, but its result and any table update wait until the output frees.
module first_fit_arena_allocator_unit #(
  parameter int unsigned ARENA_BYTES = ffa_pkg::ARENA_BYTES_DEF,
  parameter int unsigned MAX_ENTRIES = ffa_pkg::MAX_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ffa_pkg::KW-1:0]    in_kind,
  input  logic [ffa_pkg::LW-1:0]    in_length,
  input  logic [ffa_pkg::LW-1:0]    in_alignment,
  input  logic [ffa_pkg::OW-1:0]    in_offset,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ffa_pkg::STW-1:0]   out_status,
  output logic [ffa_pkg::OW-1:0]    out_block_start
);
  import ffa_pkg::*;

  localparam int SW  = $clog2(ARENA_BYTES);
  localparam int CNW = $clog2(MAX_ENTRIES + 1);
  localparam int CIW = $clog2(MAX_ENTRIES);
  localparam logic [WW-1:0]  ARENA_W = WW'(ARENA_BYTES);
  localparam logic [CNW-1:0] MAX_C   = CNW'(MAX_ENTRIES);

  state_t          state_r, state_nxt;
  logic [CNW-1:0]  idx_r, idx_nxt;
  logic [CNW-1:0]  count_r, count_nxt;
  req_t            req_r;
  kind_t           kind_r;
  logic            bad_r;
  logic            out_valid_r, out_valid_nxt;
  logic [STW-1:0]  status_r, status_nxt;
  logic [OW-1:0]   bstart_r, bstart_nxt;

  logic            accept, out_free, fire, advance;
  logic            bad_in;
  logic [LW-1:0]   align_m1;
  cell_cmd_t       cmd;

  logic [SW-1:0]   start_a [MAX_ENTRIES];
  logic [LW-1:0]   len_a   [MAX_ENTRIES];
  cell_flags_t     flags_a [MAX_ENTRIES];

  logic            at_end;
  cell_flags_t     fl;
  logic [WW-1:0]   tail_end, tail_cand, mask_w, len_w;

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic [SW-1:0] ls, rs;
      logic [LW-1:0] ll, rl;
      logic [WW-1:0] le;
      if (g == 0) begin : g_first
        assign ls = '0;
        assign ll = '0;
        assign le = '0;
      end else begin : g_mid
        assign ls = start_a[g-1];
        assign ll = len_a[g-1];
        assign le = flags_a[g-1].end_ofs;
      end
      if (g == MAX_ENTRIES - 1) begin : g_last
        assign rs = start_a[g];
        assign rl = len_a[g];
      end else begin : g_inner
        assign rs = start_a[g+1];
        assign rl = len_a[g+1];
      end
      ffa_cell #(.IDX(g), .SW(SW)) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .req        (req_r),
        .left_start (ls),
        .left_len   (ll),
        .right_start(rs),
        .right_len  (rl),
        .left_end   (le),
        .start_o    (start_a[g]),
        .len_o      (len_a[g]),
        .flags      (flags_a[g])
      );
    end
  endgenerate

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign align_m1 = in_alignment - LW'(1);
  always_comb begin
    case (kind_t'(in_kind))
      KIND_ALLOC: bad_in = (in_length == '0) || (WW'(in_length) > ARENA_W) ||
                           (in_alignment == '0) || ((in_alignment & align_m1) != '0);
      KIND_FREE, KIND_CHECK: bad_in = 1'b0;
      default: bad_in = 1'b1;
    endcase
  end

  always_comb begin
    mask_w    = WW'(req_r.mask);
    len_w     = WW'(req_r.len);
    at_end    = (idx_r == count_r);
    fl        = flags_a[idx_r[CIW-1:0]];
    tail_end  = (count_r == '0) ? '0 : flags_a[CIW'(count_r - CNW'(1))].end_ofs;
    tail_cand = (tail_end + mask_w) & ~mask_w;
  end

  // scan decision, result and table command
  always_comb begin
    logic done;
    logic [STW-1:0] st;
    logic [WW-1:0] where;
    cell_op_t op;
    logic [PW-1:0] pos;
    done  = 1'b0;
    st    = ST_OK;
    where = '0;
    op    = OP_HOLD;
    pos   = PW'(idx_r);
    if (state_r == S_SCAN) begin
      if (bad_r) begin
        done = 1'b1;
        st   = ST_BAD;
      end else if (at_end) begin
        done = 1'b1;
        if (kind_r == KIND_ALLOC) begin
          if ((tail_cand > ARENA_W) || ((ARENA_W - tail_cand) < len_w)) begin
            st = ST_NOSPACE;
          end else if (count_r >= MAX_C) begin
            st = ST_FULL;
          end else begin
            where = tail_cand;
            op    = OP_INSERT;
          end
        end else begin
          st = ST_MISS;
        end
      end else begin
        case (kind_r)
          KIND_ALLOC: begin
            if (fl.fit) begin
              done = 1'b1;
              if (count_r >= MAX_C) begin
                st = ST_FULL;
              end else begin
                where = fl.cand;
                op    = OP_INSERT;
              end
            end
          end
          KIND_FREE: begin
            if (fl.match) begin
              done = 1'b1;
              op   = OP_DELETE;
            end
          end
          KIND_CHECK: done = fl.in_span;
          default: begin
            done = 1'b1;
            st   = ST_BAD;
          end
        endcase
      end
    end
    fire       = done && out_free;
    advance    = (state_r == S_SCAN) && !done;
    status_nxt = fire ? st : status_r;
    bstart_nxt = fire ? where[OW-1:0] : bstart_r;
    cmd.op     = fire ? op : OP_HOLD;
    cmd.pos    = pos;
    cmd.start  = where;
    cmd.len    = req_r.len;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_SCAN;
      S_SCAN:  if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (accept) idx_nxt = '0;
    else if (advance) idx_nxt = idx_r + CNW'(1);
    count_nxt = count_r;
    if (cmd.op == OP_INSERT) count_nxt = count_r + CNW'(1);
    else if (cmd.op == OP_DELETE) count_nxt = count_r - CNW'(1);
    out_valid_nxt = fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.len  <= in_length;
      req_r.mask <= align_m1;
      req_r.off  <= in_offset;
      kind_r     <= kind_t'(in_kind);
      bad_r      <= bad_in;
    end
    status_r <= status_nxt;
    bstart_r <= bstart_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_block_start = bstart_r;

endmodule
